// File: rtl/clil_pkg.sv
// Shared types and constants for the circular list block.
package clil_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int POS_W           = 8;
  localparam int VAL_W           = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // What every cell of the row does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_ROT  = 2'd1,
    CELL_DROP = 2'd2,
    CELL_APP  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     at_tail;
    logic     at_fill;
  } cell_ctl_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;
  } in_beat_t;

  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  entry_value;
    logic                     last;
  } out_beat_t;

endpackage

// File: rtl/clil_cell.sv
// One entry of the list row: holds, or takes its right neighbour, the head, or a new value.
module clil_cell (
  input  logic                             clk,
  input  clil_pkg::cell_ctl_t              ctl,
  input  logic signed [clil_pkg::VAL_W-1:0] head_i,
  input  logic signed [clil_pkg::VAL_W-1:0] right_i,
  input  logic signed [clil_pkg::VAL_W-1:0] load_i,
  output logic signed [clil_pkg::VAL_W-1:0] q_o
);
  import clil_pkg::*;

  logic signed [VAL_W-1:0] q_r;
  logic signed [VAL_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (ctl.op)
      CELL_ROT:  q_nxt = ctl.at_tail ? head_i : right_i;  // tail wraps to the head
      CELL_DROP: q_nxt = right_i;
      CELL_APP:  if (ctl.at_fill) q_nxt = load_i;
      default:   q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule

// File: rtl/clil_mod.sv
// Bit-serial remainder of the insert position by the entry count.
module clil_mod #(
  parameter int DIV_W = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [clil_pkg::POS_W-1:0] dividend,
  input  logic [DIV_W-1:0]           divisor,
  output logic                       done,
  output logic [clil_pkg::POS_W-1:0] rem
);
  import clil_pkg::*;

  localparam int BIT_W   = $clog2(POS_W);
  localparam int TRIAL_W = POS_W + 1;

  logic              busy_r;
  logic              done_r;
  logic [BIT_W-1:0]  bit_r;
  logic [POS_W-1:0]  num_r;
  logic [POS_W-1:0]  rem_r;
  logic [DIV_W-1:0]  div_r;

  logic [TRIAL_W-1:0] trial;
  logic [TRIAL_W-1:0] dv;
  logic [TRIAL_W-1:0] diff;
  logic [POS_W-1:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, num_r[POS_W-1]};
    dv      = TRIAL_W'(div_r);
    diff    = trial - dv;
    rem_nxt = (trial >= dv) ? diff[POS_W-1:0] : trial[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        bit_r  <= BIT_W'(POS_W - 1);
        num_r  <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= {num_r[POS_W-2:0], 1'b0};
        bit_r <= bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/circular_list_insert_delete.sv
// Steps: an insert takes pos mod n from the bit-serial remainder unit, rotates the ring by it,
// appends at the tail and rotates the rest of the ring; a delete walks the ring once; a read
// streams n beats, one a cycle while out_ready holds. One operation at a time: deletes and reads
// walk the cell ring and inserts rotate it, one rotation a cycle (a read stalls while out_ready is low).
// Reset (rst_n low, synchronous) empties the list and the output stage; entries need no clearing.
module circular_list_insert_delete #(
  parameter int MAX_ENTRIES = clil_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  clil_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output clil_pkg::out_beat_t out_data
);
  import clil_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MOD  = 8'b0000_0010,
    S_PRE  = 8'b0000_0100,
    S_APP  = 8'b0000_1000,
    S_POST = 8'b0001_0000,
    S_DEL  = 8'b0010_0000,
    S_READ = 8'b0100_0000,
    S_RESP = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           len_r, len_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           post_r, post_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    found_r, found_nxt;
  status_t                 status_r, status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_data_r, out_data_nxt;

  cell_op_t                cell_op;
  logic                    mod_start;
  logic                    mod_done;
  logic [POS_W-1:0]        mod_rem;
  logic                    ofree;
  logic                    hit;

  logic signed [VAL_W-1:0] cell_q [MAX_ENTRIES];
  cell_ctl_t               cell_ctl [MAX_ENTRIES];

  clil_mod #(
    .DIV_W (CW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_data.position),
    .divisor  (len_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic signed [VAL_W-1:0] right;

    always_comb begin
      cell_ctl[i].op      = cell_op;
      cell_ctl[i].at_tail = (CW'(i) == (len_r - CW'(1)));
      cell_ctl[i].at_fill = (CW'(i) == len_r);
    end

    if (i == MAX_ENTRIES - 1) begin : g_end
      assign right = cell_q[i];
    end else begin : g_mid
      assign right = cell_q[i+1];
    end

    clil_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[i]),
      .head_i  (cell_q[0]),
      .right_i (right),
      .load_i  (val_r),
      .q_o     (cell_q[i])
    );
  end

  assign ofree = !out_valid_r || out_ready;
  assign hit   = (cell_q[0] == val_r);

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    post_nxt      = post_r;
    val_nxt       = val_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cell_op       = CELL_HOLD;
    mod_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = in_data.value;
          case (in_data.opcode)
            OP_INSERT: begin
              status_nxt = ST_OK;
              if (len_r == CW'(MAX_ENTRIES)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else if (len_r == '0) begin
                post_nxt  = '0;
                state_nxt = S_APP;
              end else if (in_data.position == '0) begin
                // new head: append at the tail, then rotate by the old entry count so it comes round to the head
                post_nxt  = len_r;
                state_nxt = S_APP;
              end else begin
                mod_start = 1'b1;
                state_nxt = S_MOD;
              end
            end
            OP_DELETE: begin
              if (len_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                cnt_nxt   = len_r;
                found_nxt = 1'b0;
                state_nxt = S_DEL;
              end
            end
            OP_READ: begin
              if (len_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                cnt_nxt   = len_r;
                state_nxt = S_READ;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          if (mod_rem == '0) begin
            post_nxt  = '0;
            state_nxt = S_APP;
          end else begin
            cnt_nxt   = CW'(mod_rem);
            post_nxt  = len_r - CW'(mod_rem);
            state_nxt = S_PRE;
          end
        end
      end
      S_PRE: begin
        cell_op = CELL_ROT;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) state_nxt = S_APP;
      end
      S_APP: begin
        cell_op = CELL_APP;
        len_nxt = len_r + CW'(1);
        if (post_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          cnt_nxt   = post_r;
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        cell_op = CELL_ROT;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) state_nxt = S_RESP;
      end
      S_DEL: begin
        // first match leaves the ring; all others go round to the tail
        if (!found_r && hit) begin
          cell_op   = CELL_DROP;
          len_nxt   = len_r - CW'(1);
          found_nxt = 1'b1;
        end else begin
          cell_op = CELL_ROT;
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          status_nxt = (found_r || hit) ? ST_OK : ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end
      end
      S_READ: begin
        if (ofree) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = ST_OK;
          out_data_nxt.entry_value = cell_q[0];
          out_data_nxt.last        = (cnt_r == CW'(1));
          cell_op                  = CELL_ROT;
          cnt_nxt                  = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        if (ofree) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.entry_value = '0;
          out_data_nxt.last        = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    post_r     <= post_nxt;
    val_r      <= val_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/clil_checker.sv
// Port-level checks for the circular list block, bound to the top level.
module clil_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input clil_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input clil_pkg::out_beat_t out_data
);
  import clil_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // any real operation keeps the block busy for at least the next cycle
  a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode != OP_NOP |=> !in_ready)
    else $error("input taken again straight after an operation");

  // error results are single beats with no data
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ST_OK ||
                  (out_data.last && out_data.entry_value == '0))
    else $error("error result with data or without last");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind circular_list_insert_delete clil_checker u_clil_checker (.*);
